[rtl/rhc_pkg.sv]
// rgb to hsv converter package: widths, pipeline types and the divider stage function
package rhc_pkg;

   localparam int CHAN_W         = 8;
   localparam int FRAC_W         = 16;
   localparam int BITS_PER_STAGE = 4;
   localparam int DIV_STAGES     = FRAC_W / BITS_PER_STAGE;
   localparam int HUE_W          = CHAN_W + 3;
   localparam int T_W            = HUE_W + 1;

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      chan_type                value;
      chan_type                diff;
      logic signed [CHAN_W:0]  delta;
      logic [1:0]              sector;
      logic                    sat_full;
   } front_type;

   typedef struct packed {
      chan_type            value;
      logic                sat_full;
      chan_type            sat_div;
      chan_type            sat_rem;
      logic [FRAC_W-1:0]   sat_q;
      logic [HUE_W-1:0]    hue_div;
      logic [HUE_W-1:0]    hue_rem;
      logic [FRAC_W-1:0]   hue_q;
   } div_type;

   // several restoring division steps for both quotients
   function automatic div_type div_stage(div_type s);
      div_type            r;
      logic [CHAN_W:0]    sw;
      logic [HUE_W:0]     hw;
      r = s;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         sw = {r.sat_rem, 1'b0};
         if (sw >= {1'b0, r.sat_div}) begin
            r.sat_rem = CHAN_W'(sw - {1'b0, r.sat_div});
            r.sat_q   = {r.sat_q[FRAC_W-2:0], 1'b1};
         end else begin
            r.sat_rem = sw[CHAN_W-1:0];
            r.sat_q   = {r.sat_q[FRAC_W-2:0], 1'b0};
         end
         hw = {r.hue_rem, 1'b0};
         if (hw >= {1'b0, r.hue_div}) begin
            r.hue_rem = HUE_W'(hw - {1'b0, r.hue_div});
            r.hue_q   = {r.hue_q[FRAC_W-2:0], 1'b1};
         end else begin
            r.hue_rem = hw[HUE_W-1:0];
            r.hue_q   = {r.hue_q[FRAC_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

[rtl/rgb_to_hsv_converter.sv]
// rgb to hsv converter top level: max/min, hue numerator and pipelined dividers
// a beat passes through the front register, the divider input register and the divider stages
// throughput: one pixel per cycle while the output is not stalled; the pipeline holds 6 beats
// the depth comes from 16 quotient bits per divider, 4 bits per pipeline stage
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset clears all valid bits; payload registers are not reset
module rgb_to_hsv_converter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rhc_pkg::chan_type     req_red,
   input  rhc_pkg::chan_type     req_green,
   input  rhc_pkg::chan_type     req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_hue,
   output logic [15:0]           rsp_saturation,
   output rhc_pkg::chan_type     rsp_value
);
   import rhc_pkg::*;

   logic        advance;
   chan_type    mx;
   chan_type    mn;
   front_type   front_in;
   front_type   front_ff;
   logic        front_v_ff;

   logic [T_W-1:0]    d_ext;
   logic [T_W-1:0]    six_d;
   logic signed [T_W-1:0] base;
   logic signed [T_W-1:0] t_raw;
   logic [T_W-1:0]    t_fix;
   div_type           div_first;

   div_type   div_ff [0:DIV_STAGES];
   logic      div_v_ff [0:DIV_STAGES];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 1: max, min, sector and channel difference
   always_comb begin
      mx = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx) mx = req_blue;
      mn = req_red;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn) mn = req_blue;
      front_in.value    = mx;
      front_in.diff     = mx - mn;
      front_in.sat_full = (mn == '0) && (mx != '0);
      if (req_red == mx) begin
         front_in.sector = SECTOR_RED;
         front_in.delta  = $signed({1'b0, req_green}) - $signed({1'b0, req_blue});
      end else if (req_green == mx) begin
         front_in.sector = SECTOR_GREEN;
         front_in.delta  = $signed({1'b0, req_blue}) - $signed({1'b0, req_red});
      end else begin
         front_in.sector = SECTOR_BLUE;
         front_in.delta  = $signed({1'b0, req_red}) - $signed({1'b0, req_green});
      end
   end

   // stage 2: hue numerator wrapped into range, divisors
   always_comb begin
      d_ext = T_W'(front_ff.diff);
      six_d = (d_ext << 2) + (d_ext << 1);
      unique case (front_ff.sector)
         SECTOR_GREEN: base = $signed(d_ext << 1);
         SECTOR_BLUE:  base = $signed(d_ext << 2);
         default:      base = '0;
      endcase
      t_raw = base + T_W'(front_ff.delta);
      if (t_raw < 0) begin
         t_fix = $unsigned(t_raw) + six_d;
      end else begin
         t_fix = $unsigned(t_raw);
      end
      div_first.value    = front_ff.value;
      div_first.sat_full = front_ff.sat_full;
      div_first.sat_div  = (front_ff.value == '0) ? CHAN_W'(1) : front_ff.value;
      div_first.sat_rem  = front_ff.diff;
      div_first.sat_q    = '0;
      div_first.hue_div  = (front_ff.diff == '0) ? HUE_W'(1) : six_d[HUE_W-1:0];
      div_first.hue_rem  = t_fix[HUE_W-1:0];
      div_first.hue_q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
         for (int i = 0; i <= DIV_STAGES; i++) begin
            div_v_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         front_v_ff  <= req_valid;
         div_v_ff[0] <= front_v_ff;
         for (int i = 1; i <= DIV_STAGES; i++) begin
            div_v_ff[i] <= div_v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_ff  <= front_in;
         div_ff[0] <= div_first;
         for (int i = 1; i <= DIV_STAGES; i++) begin
            div_ff[i] <= div_stage(div_ff[i-1]);
         end
      end
   end

   assign rsp_valid      = div_v_ff[DIV_STAGES];
   assign rsp_value      = div_ff[DIV_STAGES].value;
   assign rsp_hue        = div_ff[DIV_STAGES].hue_q;
   assign rsp_saturation = div_ff[DIV_STAGES].sat_full ? {FRAC_W{1'b1}}
                                                       : div_ff[DIV_STAGES].sat_q;

   // black has no saturation
   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_value == '0) |-> (rsp_saturation == '0))
      else $error("nonzero saturation for black pixel");

   // zero saturation means gray, so hue must be zero
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_saturation == '0) |-> (rsp_hue == '0))
      else $error("nonzero hue for gray pixel");

   // input side only backs up when the output is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

endmodule

[dv/rgb_to_hsv_converter_tb.sv]
// testbench for rgb_to_hsv_converter: random pixel stream, handshake stalls, per-field checking
module rgb_to_hsv_converter_tb;
   import rhc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PIXELS = 1250;
   localparam int DRAIN_CYCLES  = 12;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   typedef struct packed {
      logic [15:0] hue;
      logic [15:0] saturation;
      chan_type    value;
   } hsv_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   chan_type    req_red   = '0;
   chan_type    req_green = '0;
   chan_type    req_blue  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_hue;
   logic [15:0] rsp_saturation;
   chan_type    rsp_value;

   pixel_type pixel_queue[$];
   hsv_type   expected_hsv[$];
   pixel_type next_pixel;
   hsv_type   want_hsv;
   int        mismatch_count = 0;
   int        gap_left       = 0;
   int        stall_left     = 0;
   bit        steady_flow    = 1'b0;
   bit        req_taken      = 1'b0;

   rgb_to_hsv_converter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_value      (rsp_value)
   );

   function automatic hsv_type predict_hsv(chan_type r, chan_type g, chan_type b);
      hsv_type     o;
      chan_type    mx;
      chan_type    mn;
      chan_type    d;
      logic [1:0]  sector;
      int          n;
      int          t;
      int unsigned s;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      o.value      = mx;
      o.saturation = '0;
      o.hue        = '0;
      if (mx != 0) begin
         s = (32'(d) << 16) / 32'(mx);
         o.saturation = (s > 32'hffff) ? 16'hffff : s[15:0];
      end
      if (d != 0) begin
         if (r == mx) begin
            sector = SECTOR_RED;
            n = int'(g) - int'(b);
         end else if (g == mx) begin
            sector = SECTOR_GREEN;
            n = int'(b) - int'(r);
         end else begin
            sector = SECTOR_BLUE;
            n = int'(r) - int'(g);
         end
         // sector code counts in steps of two sixths of the circle
         t = 2 * int'(sector) * int'(d) + n;
         if (t < 0) t += 6 * int'(d);
         o.hue = 16'((t * 65536) / (6 * int'(d)));
      end
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic add_pixel(chan_type r, chan_type g, chan_type b);
      pixel_queue.push_back('{r, g, b});
   endtask

   task automatic note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // driver: request beats and response back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 249) == 0) steady_flow <= !steady_flow;
         if (!req_valid || req_taken) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               next_pixel = pixel_queue.pop_front();
               req_valid <= 1'b1;
               req_red   <= next_pixel.red;
               req_green <= next_pixel.green;
               req_blue  <= next_pixel.blue;
               gap_left  <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   // monitor: predict on each request beat, check each response beat
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         expected_hsv.push_back(predict_hsv(req_red, req_green, req_blue));
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hsv.size() == 0) begin
            note_failure($sformatf("unexpected beat: hue %0d sat %0d value %0d",
                                   rsp_hue, rsp_saturation, rsp_value));
         end else begin
            want_hsv = expected_hsv.pop_front();
            if (rsp_hue !== want_hsv.hue || rsp_saturation !== want_hsv.saturation ||
                rsp_value !== want_hsv.value)
               note_failure($sformatf(
                  "mismatch: hue %0d/%0d sat %0d/%0d value %0d/%0d (expected/actual)",
                  want_hsv.hue, rsp_hue, want_hsv.saturation, rsp_saturation,
                  want_hsv.value, rsp_value));
         end
      end
   end

   initial begin
      int       kind;
      chan_type v;
      // directed: black, gray, saturated primaries, ties, wrap-around hue
      add_pixel(8'd0, 8'd0, 8'd0);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd128, 8'd128, 8'd128);
      add_pixel(8'd255, 8'd0, 8'd0);
      add_pixel(8'd0, 8'd255, 8'd0);
      add_pixel(8'd0, 8'd0, 8'd255);
      add_pixel(8'd255, 8'd255, 8'd0);
      add_pixel(8'd0, 8'd255, 8'd255);
      add_pixel(8'd255, 8'd0, 8'd255);
      add_pixel(8'd200, 8'd200, 8'd100);
      add_pixel(8'd100, 8'd200, 8'd200);
      add_pixel(8'd200, 8'd100, 8'd200);
      add_pixel(8'd255, 8'd0, 8'd1);
      add_pixel(8'd255, 8'd10, 8'd200);
      add_pixel(8'd10, 8'd255, 8'd0);
      add_pixel(8'd1, 8'd0, 8'd0);
      add_pixel(8'd1, 8'd1, 8'd0);
      add_pixel(8'd0, 8'd0, 8'd1);
      add_pixel(8'd254, 8'd255, 8'd253);
      add_pixel(8'd170, 8'd85, 8'd0);
      add_pixel(8'd255, 8'd254, 8'd254);
      add_pixel(8'd85, 8'd170, 8'd255);
      add_pixel(8'd3, 8'd2, 8'd1);
      add_pixel(8'd128, 8'd64, 8'd200);
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         kind = $urandom_range(0, 9);
         v    = chan_type'($urandom_range(0, 255));
         unique case (kind)
            0: add_pixel(v, v, v);
            1: add_pixel(v, v, chan_type'($urandom_range(0, v)));
            2: add_pixel(v, chan_type'($urandom_range(0, v)), v);
            3: add_pixel(chan_type'($urandom_range(0, v)), v, v);
            4: add_pixel(chan_type'($urandom_range(0, 3)), chan_type'($urandom_range(0, 3)),
                         chan_type'($urandom_range(0, 3)));
            5: add_pixel($urandom_range(0, 1) ? 8'hff : 8'h00,
                         $urandom_range(0, 1) ? 8'hff : 8'h00,
                         $urandom_range(0, 1) ? 8'hff : 8'h00);
            default: add_pixel(chan_type'($urandom), chan_type'($urandom),
                               chan_type'($urandom));
         endcase
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pixel_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_hsv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_hsv.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
